[rtl/cst_pkg.sv]
`timescale 1ns / 1ps
// cst_pkg: shared types and constants of the cigar string tokenizer
// used by cst_front, cst_back and the top level; no dependencies

package cst_pkg;

  // result kinds as they appear on the kind port
  typedef enum logic [1:0] {
    KIND_OP    = 2'd0,
    KIND_VALID = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  localparam int KIND_W      = 2;
  localparam int CODE_W      = 8;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 64;
  localparam int MASK_W      = 256;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_OP_MASK_0 = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OP_MASK_1 = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_OP_MASK_2 = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_OP_MASK_3 = 8'd3;

  // character codes
  localparam logic [CODE_W-1:0] CHAR_END  = 8'h00;
  localparam logic [CODE_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CODE_W-1:0] CHAR_NINE = 8'h39;

  // depth of the token queue between front and back
  localparam int QUEUE_DEPTH = 4;

endpackage

[rtl/cigar_string_tokenizer.sv]
`timescale 1ns / 1ps
// cigar_string_tokenizer: streaming CIGAR string splitter, top level
// depends on cst_pkg, cst_front, cst_queue, cst_back
//
// usage
//   char channel: one string byte per request (char_in), a zero byte ends the
//   string. digits build a run length, any other byte is an operation code
//   result channel: kind 0 gives op_code and op_length of a kept operation,
//   kind 1 marks a valid string end, kind 2 a parse error with char_position
//   config port: cfg_write with cfg_index 0..3 loads the 64-bit slices of the
//   256-bit operation mask; other indexes are ignored. write only when idle
// timing
//   one byte per cycle sustained while the token queue has room. the byte that
//   closes a result is written into the token queue, and the output register
//   then loads it from the queue head once the output register is free or
//   not stalled. bytes that close nothing produce no result
// stall behavior
//   the front keeps taking bytes while the four-entry token queue has room,
//   so a stalled receiver only pushes back on char_stall once the queue and
//   the output register are full
// reset
//   synchronous, active high: clears run length, pending flag, character
//   count, queue and output valid; the mask returns to all ones (keep all)

module cigar_string_tokenizer #(
  parameter int LENGTH_WIDTH   = 28,
  parameter int POSITION_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // char channel
  input  logic                            char_valid,
  output logic                            char_stall,
  input  logic [cst_pkg::CODE_W-1:0]      char_in,
  // result channel
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [cst_pkg::KIND_W-1:0]      kind,
  output logic [cst_pkg::CODE_W-1:0]      op_code,
  output logic [LENGTH_WIDTH-1:0]         op_length,
  output logic [POSITION_WIDTH-1:0]       char_position,
  // config write port
  input  logic                            cfg_write,
  input  logic [cst_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cst_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // packed token: kind, code, length, position
  localparam int ENTRY_W = cst_pkg::KIND_W + cst_pkg::CODE_W + LENGTH_WIDTH + POSITION_WIDTH;

  logic               push;
  logic [ENTRY_W-1:0] push_data;
  logic               pop;
  logic [ENTRY_W-1:0] head_data;
  logic               queue_full;
  logic               queue_empty;

  // front: classifies bytes and tracks the open run
  cst_front #(
    .LENGTH_WIDTH   (LENGTH_WIDTH),
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_in    (char_in),
    .char_stall (char_stall),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  // decoupling queue between front and back
  cst_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (cst_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head_data (head_data),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  // back: mask filter and output register
  cst_back #(
    .LENGTH_WIDTH   (LENGTH_WIDTH),
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .head_data     (head_data),
    .queue_empty   (queue_empty),
    .pop           (pop),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .kind          (kind),
    .op_code       (op_code),
    .op_length     (op_length),
    .char_position (char_position)
  );

endmodule

[rtl/cst_queue.sv]
`timescale 1ns / 1ps
// cst_queue: small register fifo carrying packed tokens from front to back
// generic, no package dependencies

module cst_queue #(
  parameter int WIDTH = 54,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  assign full      = (count == FULL_COUNT);
  assign empty     = (count == '0);
  assign head_data = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + CNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

[rtl/cst_front.sv]
`timescale 1ns / 1ps
// cst_front: accepts string bytes, builds run lengths and counts characters
// pushes operation and end-of-string tokens; depends on cst_pkg

module cst_front #(
  parameter int LENGTH_WIDTH   = 28,
  parameter int POSITION_WIDTH = 16,
  localparam int ENTRY_W = cst_pkg::KIND_W + cst_pkg::CODE_W + LENGTH_WIDTH + POSITION_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       char_valid,
  input  logic [cst_pkg::CODE_W-1:0] char_in,
  output logic                       char_stall,
  input  logic                       queue_full,
  output logic                       push,
  output logic [ENTRY_W-1:0]         push_data
);

  localparam int PROD_W = LENGTH_WIDTH + 4;

  logic [LENGTH_WIDTH-1:0]   length_accum;
  logic [LENGTH_WIDTH-1:0]   length_accum_next;
  logic                      op_pending;
  logic                      op_pending_next;
  logic [POSITION_WIDTH-1:0] char_count;
  logic [POSITION_WIDTH-1:0] char_count_next;

  logic                      accept;
  logic                      is_end;
  logic                      is_digit;
  logic [3:0]                digit;
  logic [PROD_W-1:0]         scaled;
  logic [PROD_W-1:0]         scaled_sum;
  logic                      overflow;

  cst_pkg::kind_t            tok_kind;
  logic [cst_pkg::CODE_W-1:0] tok_code;
  logic [LENGTH_WIDTH-1:0]   tok_length;
  logic [POSITION_WIDTH-1:0] tok_position;

  assign char_stall = queue_full;
  assign accept     = char_valid && !queue_full;
  assign is_end     = (char_in == cst_pkg::CHAR_END);
  assign is_digit   = (char_in >= cst_pkg::CHAR_ZERO) && (char_in <= cst_pkg::CHAR_NINE);
  assign digit      = 4'(char_in - cst_pkg::CHAR_ZERO);

  // times ten as shift and add, then saturate on any carry past the width
  assign scaled     = {1'b0, length_accum, 3'b000} + {3'b000, length_accum, 1'b0};
  assign scaled_sum = scaled + PROD_W'(digit);
  assign overflow   = (scaled_sum[PROD_W-1:LENGTH_WIDTH] != '0);

  always_comb begin
    length_accum_next = length_accum;
    op_pending_next   = op_pending;
    char_count_next   = char_count;
    push              = 1'b0;
    tok_kind          = cst_pkg::KIND_OP;
    tok_code          = '0;
    tok_length        = '0;
    tok_position      = '0;
    if (accept) begin
      if (is_end) begin
        push = 1'b1;
        if (op_pending) begin
          tok_kind     = cst_pkg::KIND_ERROR;
          tok_position = char_count;
        end else begin
          tok_kind = cst_pkg::KIND_VALID;
        end
        length_accum_next = '0;
        op_pending_next   = 1'b0;
        char_count_next   = '0;
      end else begin
        if (char_count != '1) begin
          char_count_next = char_count + POSITION_WIDTH'(1);
        end
        if (is_digit) begin
          length_accum_next = overflow ? '1 : scaled_sum[LENGTH_WIDTH-1:0];
          op_pending_next   = 1'b1;
        end else if (length_accum == '0) begin
          // operation without a run is skipped but stays open
          op_pending_next = 1'b1;
        end else begin
          push              = 1'b1;
          tok_kind          = cst_pkg::KIND_OP;
          tok_code          = char_in;
          tok_length        = length_accum;
          length_accum_next = '0;
          op_pending_next   = 1'b0;
        end
      end
    end
  end

  assign push_data = {tok_kind, tok_code, tok_length, tok_position};

  always_ff @(posedge clk) begin
    if (rst) begin
      length_accum <= '0;
      op_pending   <= 1'b0;
      char_count   <= '0;
    end else begin
      length_accum <= length_accum_next;
      op_pending   <= op_pending_next;
      char_count   <= char_count_next;
    end
  end

endmodule

[rtl/cst_back.sv]
`timescale 1ns / 1ps
// cst_back: holds the operation mask, filters tokens and drives the result register
// depends on cst_pkg

module cst_back #(
  parameter int LENGTH_WIDTH   = 28,
  parameter int POSITION_WIDTH = 16,
  localparam int ENTRY_W = cst_pkg::KIND_W + cst_pkg::CODE_W + LENGTH_WIDTH + POSITION_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [cst_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cst_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [ENTRY_W-1:0]              head_data,
  input  logic                            queue_empty,
  output logic                            pop,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [cst_pkg::KIND_W-1:0]      kind,
  output logic [cst_pkg::CODE_W-1:0]      op_code,
  output logic [LENGTH_WIDTH-1:0]         op_length,
  output logic [POSITION_WIDTH-1:0]       char_position
);

  localparam int POS_LO  = 0;
  localparam int LEN_LO  = POSITION_WIDTH;
  localparam int CODE_LO = POSITION_WIDTH + LENGTH_WIDTH;
  localparam int KIND_LO = CODE_LO + cst_pkg::CODE_W;

  logic [cst_pkg::CFG_DATA_W-1:0] op_mask_0;
  logic [cst_pkg::CFG_DATA_W-1:0] op_mask_1;
  logic [cst_pkg::CFG_DATA_W-1:0] op_mask_2;
  logic [cst_pkg::CFG_DATA_W-1:0] op_mask_3;
  logic [cst_pkg::MASK_W-1:0]     mask_all;

  cst_pkg::kind_t                 head_kind;
  logic [cst_pkg::CODE_W-1:0]     head_code;
  logic                           keep;
  logic                           load;
  cst_pkg::kind_t                 kind_reg;

  assign head_kind = cst_pkg::kind_t'(head_data[KIND_LO +: cst_pkg::KIND_W]);
  assign head_code = head_data[CODE_LO +: cst_pkg::CODE_W];
  assign mask_all  = {op_mask_3, op_mask_2, op_mask_1, op_mask_0};

  // end tokens always pass; operations only when their mask bit is set
  assign keep = (head_kind != cst_pkg::KIND_OP) || mask_all[head_code];
  assign pop  = !queue_empty && (!result_valid || !result_stall);
  assign load = pop && keep;
  assign kind = kind_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_mask_0 <= '1;
      op_mask_1 <= '1;
      op_mask_2 <= '1;
      op_mask_3 <= '1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        cst_pkg::REG_OP_MASK_0: op_mask_0 <= cfg_data;
        cst_pkg::REG_OP_MASK_1: op_mask_1 <= cfg_data;
        cst_pkg::REG_OP_MASK_2: op_mask_2 <= cfg_data;
        cst_pkg::REG_OP_MASK_3: op_mask_3 <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_reg      <= head_kind;
      op_code       <= head_code;
      op_length     <= head_data[LEN_LO +: LENGTH_WIDTH];
      char_position <= head_data[POS_LO +: POSITION_WIDTH];
    end
  end

endmodule
